// File: hw/rtl/sha_pkg.sv
// ---------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ---------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = 2;

  typedef logic [31:0] word_t;

  // Block handed from the front part to the compression engine.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;   // emit digest after this block
  } blk_cmd_t;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// File: hw/rtl/sha_front.sv
// ---------------------------------------------------------------------------
// sha_front
// Gathers bytes into 512-bit blocks, adds padding and length on the end mark.
// ---------------------------------------------------------------------------
module sha_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        data_byte,
  input  logic              has_byte,
  input  logic              end_of_message,
  output logic              blk_valid,
  input  logic              blk_ready,
  output sha_pkg::blk_cmd_t blk
);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_EXTRA   = 3'b010,
    ST_LEN     = 3'b100
  } fstate_t;

  fstate_t      state;
  logic [511:0] buffer;
  logic [5:0]   fill;
  logic [63:0]  message_bits;
  logic [63:0]  total;

  logic         take;
  logic         blk_load;
  logic [511:0] buf_b;       // buffer with this item's byte placed
  logic [6:0]   fill_b;
  logic [511:0] pad_blk;
  logic [5:0]   pad_pos;
  logic [63:0]  len_bits;

  assign full = (state != ST_COLLECT) || !blk_ready;
  assign take = push && !full;
  // a new block goes out on a full block or an end mark, or from the trailing states
  assign blk_load = (state == ST_COLLECT) ? (take && (fill_b[6] || end_of_message))
                                          : (!blk_valid || blk_ready);

  always_comb begin
    buf_b  = buffer;
    fill_b = {1'b0, fill};
    if (has_byte) begin
      buf_b[511 - 8*fill -: 8] = data_byte;
      fill_b = {1'b0, fill} + 7'd1;
    end
    pad_pos  = fill_b[5:0];
    len_bits = message_bits + {55'd0, fill_b[5:0], 3'd0};
    // 0x80 then zeros past the last byte; earlier bytes kept
    pad_blk = buf_b;
    for (int i = 0; i < 64; i++) begin
      if (i[5:0] > pad_pos) pad_blk[511 - 8*i -: 8] = 8'h00;
    end
    pad_blk[511 - 8*pad_pos -: 8] = 8'h80;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_COLLECT;
      fill         <= '0;
      message_bits <= '0;
      blk_valid    <= 1'b0;
    end else begin
      if (blk_load) blk_valid <= 1'b1;
      else if (blk_ready) blk_valid <= 1'b0;
      unique case (state)
        ST_COLLECT: begin
          if (take) begin
            if (fill_b[6]) begin
              // block complete
              blk.block     <= buf_b;
              blk.final_blk <= 1'b0;
              message_bits  <= message_bits + 64'd512;
              fill          <= '0;
              if (end_of_message) begin
                total <= message_bits + 64'd512;
                state <= ST_EXTRA;
              end
            end else begin
              buffer <= buf_b;
              if (!end_of_message) begin
                fill <= fill_b[5:0];
              end else if (pad_pos >= 6'd56) begin
                blk.block     <= pad_blk;
                blk.final_blk <= 1'b0;
                total         <= len_bits;
                fill          <= '0;
                state         <= ST_LEN;
              end else begin
                blk.block     <= {pad_blk[511:64], len_bits};
                blk.final_blk <= 1'b1;
                message_bits  <= '0;
                fill          <= '0;
              end
            end
          end
        end
        ST_EXTRA: begin
          // message ended on a block boundary: pad block with 0x80 first
          if (!blk_valid || blk_ready) begin
            blk.block     <= {8'h80, 440'd0, total};
            blk.final_blk <= 1'b1;
            message_bits  <= '0;
            state         <= ST_COLLECT;
          end
        end
        ST_LEN: begin
          if (!blk_valid || blk_ready) begin
            blk.block     <= {448'd0, total};
            blk.final_blk <= 1'b1;
            message_bits  <= '0;
            state         <= ST_COLLECT;
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

endmodule

// File: hw/rtl/sha_queue.sv
// ---------------------------------------------------------------------------
// sha_queue
// Short block queue between the front part and the compression engine.
// ---------------------------------------------------------------------------
module sha_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  sha_pkg::blk_cmd_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output sha_pkg::blk_cmd_t rd_data
);

  sha_pkg::blk_cmd_t        slots [sha_pkg::QueueDepth];
  logic [sha_pkg::QueueAw-1:0] wp, rp;
  logic [sha_pkg::QueueAw:0]   count;
  logic wr, rd;

  assign wr_ready = (count != 3'(sha_pkg::QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) slots[wp] <= wr_data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + {2'd0, wr} - {2'd0, rd};
    end
  end

endmodule

// File: hw/rtl/sha_engine.sv
// ---------------------------------------------------------------------------
// sha_engine
// One SHA-256 round per cycle; emits the eight digest words after a final block.
// ---------------------------------------------------------------------------
module sha_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  sha_pkg::blk_cmd_t cmd,
  output logic              empty,
  input  logic              pop,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_word
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_OUT   = 4'b1000
  } estate_t;

  estate_t        state;
  sha_pkg::word_t hash [8];
  sha_pkg::word_t r [8];
  sha_pkg::word_t w [16];
  logic [5:0]     rnd;
  logic           final_blk;
  logic [2:0]     out_idx;

  sha_pkg::word_t t1, t2, s0, s1, w_new;

  always_comb begin
    t1 = r[7] + (sha_pkg::rotr(r[4], 6) ^ sha_pkg::rotr(r[4], 11) ^ sha_pkg::rotr(r[4], 25))
       + ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha_pkg::ROUND_K[rnd] + w[0];
    t2 = (sha_pkg::rotr(r[0], 2) ^ sha_pkg::rotr(r[0], 13) ^ sha_pkg::rotr(r[0], 22))
       + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
    s0 = sha_pkg::rotr(w[1], 7) ^ sha_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = sha_pkg::rotr(w[14], 17) ^ sha_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
  end

  assign cmd_ready   = (state == ST_IDLE);
  assign empty       = (state != ST_OUT);
  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rnd     <= '0;
      out_idx <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::INIT_HASH[i];
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            for (int i = 0; i < 16; i++) w[i] <= cmd.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) r[i] <= hash[i];
            final_blk <= cmd.final_blk;
            rnd       <= '0;
            state     <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          r[7] <= r[6];
          r[6] <= r[5];
          r[5] <= r[4];
          r[4] <= r[3] + t1;
          r[3] <= r[2];
          r[2] <= r[1];
          r[1] <= r[0];
          r[0] <= t1 + t2;
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + r[i];
          out_idx <= '0;
          state   <= final_blk ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (pop) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::INIT_HASH[i];
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/sha256_stream_hasher_core.sv
// ---------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream; eight digest words per finished message.
// ---------------------------------------------------------------------------
//   channel   | handshake    | payload
//   input     | push / full  | data_byte, has_byte, end_of_message
//   result    | empty / pop  | digest_word, word_index, last_word
//
// Bytes enter at one per cycle while full is low; each completed block goes to
// a four-entry queue and a single round unit compresses it, taking a new block
// only after the last one is done, so the round loop sets the sustained rate.
// Finalization adds at most one block. full rises while the front part inserts
// a trailing padding block or the queue is full. Reset (rst, synchronous)
// loads the initial hash and empties the queue.
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic              f_valid, f_ready, e_valid, e_ready;
  sha_pkg::blk_cmd_t f_blk, e_blk;

  sha_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .has_byte(has_byte), .end_of_message(end_of_message),
    .blk_valid(f_valid), .blk_ready(f_ready), .blk(f_blk)
  );

  sha_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_blk),
    .rd_valid(e_valid), .rd_ready(e_ready), .rd_data(e_blk)
  );

  sha_engine u_engine (
    .clk(clk), .rst(rst), .cmd_valid(e_valid), .cmd_ready(e_ready), .cmd(e_blk),
    .empty(empty), .pop(pop), .digest_word(digest_word), .word_index(word_index),
    .last_word(last_word)
  );

endmodule
